[sv/unordered_table_swap_remove_assert.svh]
// ----------------------------------------------------------------------------
// unordered table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef UNORDERED_TABLE_SWAP_REMOVE_ASSERT_SVH
`define UNORDERED_TABLE_SWAP_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uts assertion failed");

// next-cycle implication
`define UTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uts assertion failed");

`else

`define UTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/uts_pkg.sv]
// ----------------------------------------------------------------------------
// uts_pkg
// types and constants of the unordered table with swap remove
// ----------------------------------------------------------------------------
package uts_pkg;

  // built table depth
  localparam int unsigned DepthDefault = 256;

  // fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CapW   = 9;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = 9'd256;

  // command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_SEARCH
  } state_e;

endpackage

[sv/unordered_table_swap_remove.sv]
// Clear and append: done_o strobes in the cycle after start is taken.
// Remove: read of the newest entry, then write into the index; a failing remove skips both.
// Search: fails without a read on an empty table, else reads one entry per cycle, newest first.
// A new transaction is taken in the cycle done_o strobes; results cannot be stalled.
// Reset empties the table, sets capacity to 256; table words stay undefined until written.
// ----------------------------------------------------------------------------
// unordered_table_swap_remove
// packed table of 32-bit words with append, swap remove and reverse search
// ----------------------------------------------------------------------------
module unordered_table_swap_remove #(
  parameter int unsigned DEPTH = uts_pkg::DepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  uts_pkg::cmd_e                    command_i,
  input  logic signed [uts_pkg::ValueW-1:0] value_i,
  input  logic [uts_pkg::IndexW-1:0]       index_i,
  input  logic                             cfg_we_i,
  input  logic [uts_pkg::CapW-1:0]         cfg_wdata_i,
  output logic                             done_o,
  output logic                             ok_o,
  output logic [uts_pkg::PosW-1:0]         position_o,
  output logic [uts_pkg::CountW-1:0]       count_o
);

  `include "unordered_table_swap_remove_assert.svh"

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > uts_pkg::CapW) ? CW : uts_pkg::CapW;

  // control and payload registers
  uts_pkg::state_e state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic [AW-1:0]   index_q, index_d;
  logic signed [uts_pkg::ValueW-1:0] value_q, value_d;
  logic [uts_pkg::CapW-1:0] cap_q;
  logic            done_q, done_d;
  logic            ok_q, ok_d;
  logic [uts_pkg::PosW-1:0]   pos_q, pos_d;
  logic [uts_pkg::CountW-1:0] count_q, count_d;

  // memory ports
  logic [uts_pkg::ValueW-1:0] mem_q [DEPTH];
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [uts_pkg::ValueW-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [uts_pkg::ValueW-1:0] rd_data_q;

  // decoded conditions
  logic accept;
  logic has_entries;
  logic append_ok;
  logic remove_ok;
  logic match;
  logic [AW-1:0] last_addr;

  assign busy        = (state_q != uts_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign has_entries = (fill_q != '0);
  assign append_ok   = (CMPW'(fill_q) < CMPW'(cap_q)) && (CMPW'(fill_q) < CMPW'(DEPTH));
  assign remove_ok   = (CMPW'(index_i) < CMPW'(fill_q));
  assign match       = (rd_data_q == value_q);
  assign last_addr   = AW'(fill_q - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      uts_pkg::ST_IDLE: begin
        if (accept) begin
          if (command_i == uts_pkg::CMD_REMOVE && remove_ok) begin
            state_d = uts_pkg::ST_REMOVE;
          end else if (command_i == uts_pkg::CMD_SEARCH && has_entries) begin
            state_d = uts_pkg::ST_SEARCH;
          end
        end
      end
      uts_pkg::ST_REMOVE: begin
        state_d = uts_pkg::ST_IDLE;
      end
      uts_pkg::ST_SEARCH: begin
        if (match || scan_q == '0) begin
          state_d = uts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = uts_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory port control
  always_comb begin
    fill_d  = fill_q;
    scan_d  = scan_q;
    index_d = index_q;
    value_d = value_q;
    done_d  = 1'b0;
    ok_d    = 1'b0;
    pos_d   = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(fill_q);
    wr_data = value_i;
    rd_en   = 1'b0;
    rd_addr = last_addr;
    case (state_q)
      uts_pkg::ST_IDLE: begin
        if (accept) begin
          value_d = value_i;
          index_d = AW'(index_i);
          case (command_i)
            uts_pkg::CMD_CLEAR: begin
              fill_d = '0;
              done_d = 1'b1;
            end
            uts_pkg::CMD_APPEND: begin
              done_d = 1'b1;
              if (append_ok) begin
                wr_en  = 1'b1;
                fill_d = fill_q + 1'b1;
                ok_d   = 1'b1;
              end
            end
            uts_pkg::CMD_REMOVE: begin
              // fetch the newest entry, written back next cycle
              if (remove_ok) begin
                rd_en = 1'b1;
              end else begin
                done_d = 1'b1;
              end
            end
            uts_pkg::CMD_SEARCH: begin
              // start the scan at the newest entry
              if (has_entries) begin
                rd_en  = 1'b1;
                scan_d = last_addr;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      uts_pkg::ST_REMOVE: begin
        wr_en   = 1'b1;
        wr_addr = index_q;
        wr_data = rd_data_q;
        fill_d  = fill_q - 1'b1;
        done_d  = 1'b1;
        ok_d    = 1'b1;
      end
      uts_pkg::ST_SEARCH: begin
        if (match) begin
          done_d = 1'b1;
          ok_d   = 1'b1;
          pos_d  = uts_pkg::PosW'(scan_q);
        end else if (scan_q == '0) begin
          done_d = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q - 1'b1;
          scan_d  = scan_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    count_d = uts_pkg::CountW'(fill_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uts_pkg::ST_IDLE;
      fill_q  <= '0;
      cap_q   <= uts_pkg::CapReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    index_q <= index_d;
    value_q <= value_d;
    if (done_d) begin
      ok_q    <= ok_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign done_o     = done_q;
  assign ok_o       = ok_q;
  assign position_o = pos_q;
  assign count_o    = count_q;

  // checks
  `UTS_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, CMPW'(fill_q) <= CMPW'(DEPTH))
  `UTS_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == uts_pkg::ST_IDLE)
  `UTS_ASSERT_IMPL(a_scan_below_fill, clk_i, rst_ni, state_q == uts_pkg::ST_SEARCH,
                   CMPW'(scan_q) < CMPW'(fill_q))
  `UTS_ASSERT_NEXT(a_short_cmd_done, clk_i, rst_ni,
                   accept && (command_i == uts_pkg::CMD_CLEAR ||
                              command_i == uts_pkg::CMD_APPEND), done_q)

endmodule

[sim/table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_checker
// tracks the expected table contents and fill count, and scores every result
// ----------------------------------------------------------------------------
module table_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  uts_pkg::cmd_e                     command_i,
  input  logic signed [uts_pkg::ValueW-1:0] value_i,
  input  logic [uts_pkg::IndexW-1:0]        index_i,
  input  logic                              cfg_we_i,
  input  logic [uts_pkg::CapW-1:0]          cfg_wdata_i,
  input  logic                              done_o,
  input  logic                              ok_o,
  input  logic [uts_pkg::PosW-1:0]          position_o,
  input  logic [uts_pkg::CountW-1:0]        count_o,
  output int                                fail_count_o,
  output int                                pending_o,
  output logic [uts_pkg::CountW-1:0]        stored_count_o
);

  localparam int unsigned Depth = uts_pkg::DepthDefault;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef struct packed {
    logic                       ok;
    logic [uts_pkg::PosW-1:0]   position;
    logic [uts_pkg::CountW-1:0] count;
  } table_result_t;

  // shadow of the table
  logic signed [uts_pkg::ValueW-1:0] table_words [Depth];
  logic [uts_pkg::CountW-1:0]        fill_level;
  logic [uts_pkg::CapW-1:0]          capacity_q;
  table_result_t                     expected_results [$];
  int                                mismatches;

  // apply one command to the shadow table and return its result
  function automatic table_result_t apply_table_command(
      uts_pkg::cmd_e cmd, logic signed [uts_pkg::ValueW-1:0] val,
      logic [uts_pkg::IndexW-1:0] idx);
    table_result_t res;
    int unsigned   limit;
    res = '0;
    limit = (capacity_q > Depth) ? Depth : capacity_q;
    case (cmd)
      uts_pkg::CMD_CLEAR: begin
        fill_level = '0;
      end
      uts_pkg::CMD_APPEND: begin
        if (fill_level < limit) begin
          table_words[AddrW'(fill_level)] = val;
          fill_level = fill_level + 1'b1;
          res.ok = 1'b1;
        end
      end
      uts_pkg::CMD_REMOVE: begin
        if (idx < fill_level) begin
          table_words[AddrW'(idx)] = table_words[AddrW'(fill_level - 1'b1)];
          fill_level = fill_level - 1'b1;
          res.ok = 1'b1;
        end
      end
      default: begin
        // newest entry first, the first hit wins
        for (int i = int'(fill_level) - 1; i >= 0; i--) begin
          if (table_words[AddrW'(i)] == val) begin
            res.ok = 1'b1;
            res.position = i[uts_pkg::PosW-1:0];
            break;
          end
        end
      end
    endcase
    res.count = fill_level;
    return res;
  endfunction

  // score results, then predict newly accepted transactions
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      fill_level = '0;
      capacity_q = uts_pkg::CapReset;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      stored_count_o <= '0;
    end else begin
      if (done_o) begin
        got = '{ok: ok_o, position: position_o, count: count_o};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ok=%0b position=%0d count=%0d",
                     $realtime, ok_o, position_o, count_o);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.position !== want.position ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch ok %0b/%0b position %0d/%0d count %0d/%0d",
                       $realtime, want.ok, got.ok, want.position, got.position,
                       want.count, got.count);
          end
        end
      end
      if (cfg_we_i)
        capacity_q = cfg_wdata_i;
      if (start && !busy)
        expected_results.push_back(apply_table_command(command_i, value_i, index_i));
      fail_count_o <= mismatches;
      pending_o <= expected_results.size();
      stored_count_o <= fill_level;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random table commands with random gaps and capacity
// changes; the checker predicts and scores every result
// ----------------------------------------------------------------------------
module testbench;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  uts_pkg::cmd_e                       command_i;
  logic signed [uts_pkg::ValueW-1:0]   value_i;
  logic [uts_pkg::IndexW-1:0]          index_i;
  logic                                cfg_we_i;
  logic [uts_pkg::CapW-1:0]            cfg_wdata_i;
  logic                                done_o;
  logic                                ok_o;
  logic [uts_pkg::PosW-1:0]            position_o;
  logic [uts_pkg::CountW-1:0]          count_o;
  int                                  fail_count;
  int                                  pending;
  logic [uts_pkg::CountW-1:0]          stored_count;

  logic [uts_pkg::ValueW-1:0]          value_pool [24];

  // random phases: capacity, length and command mix in percent
  int phase_cap    [8] = '{256, 17, 0, 511, 1, 300, 128, 256};
  int phase_items  [8] = '{350, 120, 60, 200, 70, 150, 120, 80};
  int phase_append [8] = '{90, 30, 40, 90, 50, 60, 45, 35};
  int phase_remove [8] = '{4, 35, 25, 4, 25, 20, 30, 40};
  int phase_clear  [8] = '{0, 0, 0, 1, 5, 2, 3, 3};

  unordered_table_swap_remove dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .ok_o       (ok_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

  table_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .position_o    (position_o),
    .count_o       (count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .stored_count_o(stored_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // hold start until the transaction is taken
  task automatic issue(input uts_pkg::cmd_e cmd, input logic [uts_pkg::ValueW-1:0] val,
                       input logic [uts_pkg::IndexW-1:0] idx);
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= cmd;
    value_i <= val;
    index_i <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  // sender gap, mostly short
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // stop sending until every result is back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // capacity write while the block is idle
  task automatic write_capacity(input logic [uts_pkg::CapW-1:0] cap);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly values from the pool so that searches hit and duplicates occur
  function automatic logic [uts_pkg::ValueW-1:0] pick_value();
    if ($urandom_range(0, 99) < 75)
      return value_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  // stimulus
  initial begin
    int r;
    logic [uts_pkg::IndexW-1:0] idx;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = uts_pkg::CMD_CLEAR;
    value_i = '0;
    index_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 24; i++) value_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, duplicates, failing removes, clear
    issue(uts_pkg::CMD_SEARCH, 32'h0000_0000, 8'd0);
    issue(uts_pkg::CMD_REMOVE, 32'h0000_0000, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'h7fff_ffff, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'h8000_0000, 8'd255);
    issue(uts_pkg::CMD_APPEND, 32'h0000_0000, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'hffff_ffff, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'h7fff_ffff, 8'd0);
    issue(uts_pkg::CMD_SEARCH, 32'h7fff_ffff, 8'd0);
    issue(uts_pkg::CMD_SEARCH, 32'h8000_0000, 8'd0);
    issue(uts_pkg::CMD_SEARCH, 32'h1234_5678, 8'd0);
    issue(uts_pkg::CMD_REMOVE, 32'h0000_0000, 8'd255);
    issue(uts_pkg::CMD_REMOVE, 32'h0000_0000, 8'd5);
    issue(uts_pkg::CMD_REMOVE, 32'h0000_0000, 8'd0);
    issue(uts_pkg::CMD_REMOVE, 32'h0000_0000, 8'd3);
    issue(uts_pkg::CMD_SEARCH, 32'hffff_ffff, 8'd0);
    issue(uts_pkg::CMD_CLEAR, $urandom, 8'($urandom));
    issue(uts_pkg::CMD_SEARCH, 32'h7fff_ffff, 8'd0);

    // small capacity: third append finds the table full
    write_capacity(9'd2);
    issue(uts_pkg::CMD_APPEND, 32'hffff_ffff, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'h8000_0000, 8'd0);
    issue(uts_pkg::CMD_APPEND, 32'h0000_0001, 8'd0);
    issue(uts_pkg::CMD_SEARCH, 32'hffff_ffff, 8'd0);

    // random phases
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_cap[p][uts_pkg::CapW-1:0]);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 37 == 36)
          drain();
        else
          sender_gap();
        r = $urandom_range(0, 99);
        if (r < phase_append[p]) begin
          issue(uts_pkg::CMD_APPEND, pick_value(), 8'($urandom));
        end else if (r < phase_append[p] + phase_remove[p]) begin
          if (stored_count != 0 && $urandom_range(0, 9) < 8)
            idx = 8'($urandom_range(0, int'(stored_count) - 1));
          else
            idx = 8'($urandom_range(0, 255));
          issue(uts_pkg::CMD_REMOVE, $urandom, idx);
        end else if (r < phase_append[p] + phase_remove[p] + phase_clear[p]) begin
          issue(uts_pkg::CMD_CLEAR, $urandom, 8'($urandom));
        end else begin
          issue(uts_pkg::CMD_SEARCH, pick_value(), 8'($urandom));
        end
      end
    end

    // wind down and report
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
